// ----- rtl/pem_pkg.sv -----
// shared constants for the modular polynomial evaluator
// no dependencies; imported by pem_step, polynomial_eval_modular_unit and the testbench
package pem_pkg;

	localparam int DEF_WORD_BITS = 64;
	localparam int FIELD_BITS    = 64;
	localparam int ADDR_BITS     = 4;
	localparam int DATA_BITS     = 64;

	localparam logic REG_MODULUS = 1'b0;

endpackage

// ----- rtl/pem_step.sv -----
// shared modular step: optional doubling then addition, both modulo m
// depends on pem_pkg; operands r and a must satisfy r < m and a <= m
module pem_step #(
	parameter int WORD_BITS = pem_pkg::DEF_WORD_BITS
) (
	input  logic [WORD_BITS-1:0] r,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] m,
	input  logic                 dbl,
	output logic [WORD_BITS-1:0] s
);
	import pem_pkg::*;

	logic [WORD_BITS:0]   twice;
	logic [WORD_BITS:0]   twice_red;
	logic [WORD_BITS-1:0] base;
	logic [WORD_BITS:0]   sum;
	logic [WORD_BITS:0]   sum_red;

	always_comb begin
		twice     = {r, 1'b0};
		twice_red = (twice >= {1'b0, m}) ? (twice - {1'b0, m}) : twice;
		base      = dbl ? twice_red[WORD_BITS-1:0] : r;
		sum       = {1'b0, base} + {1'b0, a};
		sum_red   = (sum >= {1'b0, m}) ? (sum - {1'b0, m}) : sum;
		s         = sum_red[WORD_BITS-1:0];
	end

endmodule

// ----- rtl/polynomial_eval_modular_unit.sv -----
// horner evaluation modulo a configured modulus, one coefficient per transaction
// depends on pem_pkg and pem_step; one shared modular step unit, one bit per cycle
// sequence: optional coefficient reduction, optional accumulator reduction, multiply, add, output
// (coefficient reduction and accumulator reduction are skipped when already below modulus)
// input stalls while busy, so a new term is accepted only after the previous one has left the output step
// reset: accumulator cleared, modulus set to one, no result pending
module polynomial_eval_modular_unit #(
	parameter int WORD_BITS = pem_pkg::DEF_WORD_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pem_pkg::FIELD_BITS-1:0] coefficient,
	input  logic [pem_pkg::FIELD_BITS-1:0] point,
	input  logic                           last_term,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [pem_pkg::FIELD_BITS-1:0] value,
	output logic                           is_root,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pem_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [pem_pkg::DATA_BITS-1:0]  pwdata,
	output logic [pem_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready
);
	import pem_pkg::*;

	localparam int CNT_BITS = $clog2(WORD_BITS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_REDC = 3'd1;
	localparam logic [2:0] S_REDA = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_ADD  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]             state_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic                   out_valid_q;
	logic [WORD_BITS-1:0]   acc_q;
	logic [DATA_BITS-1:0]   modulus_q;

	logic [WORD_BITS-1:0]   sh_q;
	logic [WORD_BITS-1:0]   r_q;
	logic [WORD_BITS-1:0]   cr_q;
	logic [WORD_BITS-1:0]   a_q;
	logic [WORD_BITS-1:0]   point_q;
	logic                   last_q;
	logic [FIELD_BITS-1:0]  value_q;
	logic                   is_root_q;

	logic [WORD_BITS-1:0]   m_masked;
	logic [WORD_BITS-1:0]   m_act;
	logic [WORD_BITS-1:0]   coef_in;
	logic [WORD_BITS-1:0]   addend;
	logic                   dbl;
	logic [WORD_BITS-1:0]   step_s;
	logic                   cnt_done;
	logic                   coef_small;
	logic                   acc_small;
	logic                   out_free;
	logic                   cfg_wr;

	assign m_masked   = modulus_q[WORD_BITS-1:0];
	assign m_act      = (m_masked == '0) ? WORD_BITS'(1) : m_masked;
	assign coef_in    = coefficient[WORD_BITS-1:0];
	assign cnt_done   = (cnt_q == '0);
	assign coef_small = (coef_in < m_act);
	assign acc_small  = (acc_q < m_act);
	assign out_free   = !out_valid_q || !out_stall;
	assign cfg_wr     = psel && penable && pwrite && pready;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign is_root   = is_root_q;
	assign prdata    = modulus_q;
	assign pready    = 1'b1;

	always_comb begin
		dbl = (state_q != S_ADD);
		case (state_q)
			S_REDC, S_REDA: addend = WORD_BITS'(sh_q[WORD_BITS-1]);
			S_MUL:          addend = sh_q[WORD_BITS-1] ? a_q : '0;
			S_ADD:          addend = cr_q;
			default:        addend = '0;
		endcase
	end

	pem_step #(
		.WORD_BITS(WORD_BITS)
	) u_step (
		.r  (r_q),
		.a  (addend),
		.m  (m_act),
		.dbl(dbl),
		.s  (step_s)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			modulus_q   <= DATA_BITS'(1);
		end else begin
			if (cfg_wr && (paddr[3] == REG_MODULUS)) begin
				modulus_q <= pwdata;
			end
			if ((state_q == S_OUT) && last_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q <= CNT_BITS'(WORD_BITS - 1);
						if (!coef_small) begin
							state_q <= S_REDC;
						end else if (acc_small) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_REDA;
						end
					end
				end
				S_REDC: begin
					if (cnt_done) begin
						cnt_q   <= CNT_BITS'(WORD_BITS - 1);
						state_q <= acc_small ? S_MUL : S_REDA;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_REDA: begin
					if (cnt_done) begin
						cnt_q   <= CNT_BITS'(WORD_BITS - 1);
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_MUL: begin
					if (cnt_done) begin
						state_q <= S_ADD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_ADD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!last_q) begin
						acc_q   <= r_q;
						state_q <= S_IDLE;
					end else if (out_free) begin
						acc_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					point_q <= point[WORD_BITS-1:0];
					last_q  <= last_term;
					cr_q    <= coef_in;
					a_q     <= acc_q;
					r_q     <= '0;
					if (!coef_small) begin
						sh_q <= coef_in;
					end else if (acc_small) begin
						sh_q <= point[WORD_BITS-1:0];
					end else begin
						sh_q <= acc_q;
					end
				end
			end
			S_REDC: begin
				if (cnt_done) begin
					cr_q <= step_s;
					r_q  <= '0;
					a_q  <= acc_q;
					sh_q <= acc_small ? point_q : acc_q;
				end else begin
					r_q  <= step_s;
					sh_q <= {sh_q[WORD_BITS-2:0], 1'b0};
				end
			end
			S_REDA: begin
				if (cnt_done) begin
					a_q  <= step_s;
					r_q  <= '0;
					sh_q <= point_q;
				end else begin
					r_q  <= step_s;
					sh_q <= {sh_q[WORD_BITS-2:0], 1'b0};
				end
			end
			S_MUL: begin
				r_q  <= step_s;
				sh_q <= {sh_q[WORD_BITS-2:0], 1'b0};
			end
			S_ADD: begin
				r_q <= step_s;
			end
			S_OUT: begin
				if (last_q && out_free) begin
					value_q   <= FIELD_BITS'(r_q);
					is_root_q <= (r_q == '0);
				end
			end
			default: begin
				r_q <= r_q;
			end
		endcase
	end

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_OUT) && $past(last_q))
		else $error("result raised outside the output step of a last term");

	a_root_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (is_root_q == (value_q == '0)) && (acc_q == '0))
		else $error("root flag or accumulator clear inconsistent with result");

	a_add_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD) |=> (r_q < $past(m_act)))
		else $error("sum not reduced below modulus");

	a_mul_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) && cnt_done |=> (state_q == S_ADD))
		else $error("multiply phase did not hand over to the add step");

endmodule

// ----- sim/tb_polynomial_eval_modular_unit.sv -----
// self-checking testbench for polynomial_eval_modular_unit: horner evaluation modulo a
// register-set modulus, checked against a class-based predictor and expected-value queue
// depends on pem_pkg and the unit rtl; no files, arguments or seeds needed
module tb_polynomial_eval_modular_unit;
	import pem_pkg::*;

	localparam int WORD_BITS   = DEF_WORD_BITS;
	localparam int REG_UNUSED  = 1;
	localparam int SETTLE_CYC  = 3 * WORD_BITS + 8;
	localparam int STALL_LIMIT = 20000;
	localparam int PHASE_ITEMS = 136;
	localparam int NUM_PHASES  = 9;

	typedef struct packed {
		logic [63:0] value;
		logic        is_root;
	} poly_value_t;

	class poly_eval_scoreboard;
		logic [63:0] modulus_reg;
		logic [63:0] acc;
		poly_value_t expected_values[$];
		int          errors;

		function new();
			modulus_reg = 64'd1;
			acc         = 64'd0;
			errors      = 0;
		endfunction

		function void write_register(int idx, logic [63:0] v);
			if (idx == int'(REG_MODULUS)) begin
				modulus_reg = v;
			end
		endfunction

		function logic [63:0] eff_modulus();
			logic [63:0] m;
			m = modulus_reg & ({64{1'b1}} >> (64 - WORD_BITS));
			return (m == 64'd0) ? 64'd1 : m;
		endfunction

		// one horner step on the held accumulator, operands reduced first
		function logic [63:0] horner_step(logic [63:0] coef, logic [63:0] pt);
			logic [63:0]  m;
			logic [63:0]  mask;
			logic [63:0]  c;
			logic [63:0]  x;
			logic [63:0]  a;
			logic [127:0] prod;
			logic [64:0]  s;
			mask = {64{1'b1}} >> (64 - WORD_BITS);
			m    = eff_modulus();
			c    = (coef & mask) % m;
			x    = (pt & mask) % m;
			a    = acc % m;
			prod = ({64'd0, a} * {64'd0, x}) % {64'd0, m};
			s    = {1'b0, prod[63:0]} + {1'b0, c};
			if (s >= {1'b0, m}) begin
				s = s - {1'b0, m};
			end
			return s[63:0];
		endfunction

		// constant term that brings the open polynomial to zero
		function logic [63:0] root_completion(logic [63:0] pt);
			logic [63:0] t;
			t = horner_step(64'd0, pt);
			return (t == 64'd0) ? 64'd0 : eff_modulus() - t;
		endfunction

		function void note_input(logic [63:0] coef, logic [63:0] pt, logic last);
			logic [63:0] n;
			poly_value_t e;
			n = horner_step(coef, pt);
			if (last) begin
				e.value         = n;
				e.is_root       = (n == 64'd0);
				expected_values = {expected_values, e};
				acc             = 64'd0;
			end else begin
				acc = n;
			end
		endfunction

		function void check_result(logic [63:0] v, logic r);
			poly_value_t e;
			if (expected_values.size() == 0) begin
				$error("unexpected result transaction: value %h is_root %b", v, r);
				errors++;
				return;
			end
			e = expected_values.pop_front();
			if (v !== e.value) begin
				$error("value: expected %h, got %h", e.value, v);
				errors++;
			end
			if (r !== e.is_root) begin
				$error("is_root: expected %b, got %b", e.is_root, r);
				errors++;
			end
		endfunction

		function int pending();
			return expected_values.size();
		endfunction
	endclass

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [FIELD_BITS-1:0] coefficient = '0;
	logic [FIELD_BITS-1:0] point       = '0;
	logic                  last_term   = 1'b0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [FIELD_BITS-1:0] value;
	logic                  is_root;
	logic                  psel        = 1'b0;
	logic                  penable     = 1'b0;
	logic                  pwrite      = 1'b0;
	logic [ADDR_BITS-1:0]  paddr       = '0;
	logic [DATA_BITS-1:0]  pwdata      = '0;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;

	poly_eval_scoreboard sb = new();
	int src_idle_pct = 23;
	int dst_idle_pct = 73;
	int quiet_cycles = 0;

	polynomial_eval_modular_unit #(.WORD_BITS(WORD_BITS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.coefficient(coefficient), .point(point), .last_term(last_term),
		.out_valid(out_valid), .out_stall(out_stall),
		.value(value), .is_root(is_root),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < dst_idle_pct);
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			sb.check_result(value, is_root);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] pick_operand();
		case ($urandom_range(9))
			0: return 64'd0;
			1: return {64{1'b1}};
			2: return 64'($urandom_range(15));
			3: return sb.eff_modulus() - 64'd1;
			4: return sb.eff_modulus() + 64'($urandom_range(3));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_term(logic [63:0] c, logic [63:0] pt, logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		coefficient <= c;
		point       <= pt;
		last_term   <= last;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_input(c, pt, last);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// non-final terms give no result, so let any step still in flight finish
	task automatic settle_idle();
		wait_drained();
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_register(int idx, logic [63:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BITS'(idx * 8);
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		sb.write_register(idx, v);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		logic [63:0] moduli [NUM_PHASES];
		logic [63:0] pt;
		logic [63:0] pt_k;
		logic [63:0] c;
		logic        last;
		logic        make_root;
		int          nterms;
		int          sent;
		int          total;

		moduli[0] = {64{1'b1}};
		moduli[1] = 64'd7;
		moduli[2] = 64'hFFFF_FFFF_FFFF_FFC5;
		moduli[3] = 64'd13;
		moduli[4] = 64'd0;
		moduli[5] = {$urandom, $urandom};
		moduli[6] = 64'd2;
		moduli[7] = 64'd1;
		moduli[8] = {32'd0, $urandom} | 64'd1;
		total = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// modulus after reset is one
		send_term({64{1'b1}}, {64{1'b1}}, 1'b1);
		settle_idle();
		write_register(REG_UNUSED, 64'd5);
		send_term(64'd5, 64'd3, 1'b1);
		settle_idle();
		write_register(REG_MODULUS, 64'd0);
		send_term(64'd123, 64'd7, 1'b0);
		send_term(64'd9, 64'd7, 1'b1);
		settle_idle();
		write_register(REG_MODULUS, {64{1'b1}});
		send_term(64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
		send_term(64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
		send_term(64'd0, 64'd0, 1'b1);
		send_term({64{1'b1}}, 64'd0, 1'b1);
		send_term(64'h8000_0000_0000_0000, {64{1'b1}}, 1'b0);
		send_term(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		settle_idle();
		write_register(REG_MODULUS, 64'd7);
		send_term(64'd1, 64'd1, 1'b0);
		send_term(64'd0, 64'd1, 1'b0);
		send_term(64'd6, 64'd1, 1'b1);
		send_term(64'd8, 64'd8, 1'b0);
		send_term(64'd7, 64'd8, 1'b0);
		send_term(64'd13, 64'd8, 1'b1);
		// polynomial left open across a modulus change
		send_term(64'd1, 64'd3, 1'b0);
		send_term(64'd2, 64'd3, 1'b0);
		settle_idle();
		write_register(REG_MODULUS, 64'hFFFF_FFFF_FFFF_FFC5);
		send_term(64'd5, 64'd3, 1'b1);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle_idle();
			case (ph / 3)
				0: begin
					src_idle_pct = 23;
					dst_idle_pct = 73;
				end
				1: begin
					src_idle_pct = 73;
					dst_idle_pct = 23;
				end
				default: begin
					src_idle_pct = 0;
					dst_idle_pct = 0;
				end
			endcase
			write_register(REG_MODULUS, moduli[ph]);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				nterms    = $urandom_range(1, 6);
				pt        = pick_operand();
				make_root = ($urandom_range(2) == 0);
				for (int k = 0; k < nterms && sent < PHASE_ITEMS; k++) begin
					last = (k == nterms - 1);
					c    = pick_operand();
					pt_k = ($urandom_range(15) == 0) ? pick_operand() : pt;
					if (last && make_root) begin
						c = sb.root_completion(pt_k);
					end
					if ($urandom_range(31) == 0) begin
						last = ~last;
					end
					send_term(c, pt_k, last);
					sent++;
					total++;
					if (total % 150 == 0) begin
						wait_drained();
					end
				end
			end
		end

		wait_drained();
		repeat (SETTLE_CYC) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
